@@ hw/rtl/ccl_pkg.sv @@
// Shared constants for the grid region labeller.
`default_nettype none

package ccl_pkg;

    // Default grid bounds and type code width
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_TYPE_BITS  = 3;

    // Fixed field widths
    localparam int LABEL_W = 12;
    localparam int INDEX_W = 12;
    localparam int DIM_W   = 7;
    localparam int MASK_W  = 8;
    localparam int CFG_A_W = 2;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_TYPE_MASK   = 2'd2;

    // Item and result codes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_READ  = 1'b1;
    localparam logic KIND_COUNT = 1'b0;
    localparam logic KIND_LABEL = 1'b1;

endpackage

`default_nettype wire

@@ hw/rtl/ccl_cell_mem.sv @@
// Cell store: type code and region label per cell, one shared port.
`default_nettype none

module ccl_cell_mem #(
    parameter int DEPTH  = 4096,
    parameter int TYPE_W = 3,
    parameter int LAB_W  = 12
) (
    input  wire                     i_clk,
    input  wire [$clog2(DEPTH)-1:0] i_addr,
    input  wire                     i_re,
    input  wire                     i_we_type,
    input  wire [TYPE_W-1:0]        i_type,
    input  wire                     i_we_label,
    input  wire [LAB_W-1:0]         i_label,
    output logic [TYPE_W-1:0]       o_type,
    output logic [LAB_W-1:0]        o_label
);

    logic [TYPE_W+LAB_W-1:0] r_mem [DEPTH];

    // Field-masked write, registered read
    always_ff @(posedge i_clk) begin
        if (i_we_type) begin
            r_mem[i_addr][LAB_W +: TYPE_W] <= i_type;
        end
        if (i_we_label) begin
            r_mem[i_addr][LAB_W-1:0] <= i_label;
        end
        if (i_re) begin
            o_type  <= r_mem[i_addr][LAB_W +: TYPE_W];
            o_label <= r_mem[i_addr][LAB_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ccl_stack_mem.sv @@
// Fill stack store: one write port, one registered read port.
`default_nettype none

module ccl_stack_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 24
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/grid_connected_component_labeler_top.sv @@
// Top level: load/read front end and flood-fill sequencer for 4-connected labelling.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+---------------------------------------------
//  in      | i_in_valid / o_in_ready | i_mode, i_cell_type, i_last_cell, i_cell_index
//  out     | o_out_valid/ i_out_ready| o_kind, o_region_count, o_cell_label
//  cfg     | i_cfg_we                | i_cfg_addr, i_cfg_data
//
// A load is written into the cell store as it is taken; a read goes through S_RD_PUT,
// which waits for the output register to be free. Labelling: a clear sweep over all
// MAX_WIDTH*MAX_HEIGHT cells, a read and a check per scanned cell, and per filled cell a
// stack pop plus a read and a check of each in-grid neighbour; the single cell store port sets this.
// After reset a clear sweep over all MAX_WIDTH*MAX_HEIGHT cells runs before input is taken.
// Input is taken whenever the sequencer is idle, also while a result waits.
`default_nettype none

module grid_connected_component_labeler_top #(
    parameter int MAX_WIDTH  = ccl_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ccl_pkg::DEF_MAX_HEIGHT,
    parameter int TYPE_BITS  = ccl_pkg::DEF_TYPE_BITS
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire                           i_mode,
    input  wire [TYPE_BITS-1:0]           i_cell_type,
    input  wire                           i_last_cell,
    input  wire [ccl_pkg::INDEX_W-1:0]    i_cell_index,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic                          o_kind,
    output logic [ccl_pkg::LABEL_W-1:0]   o_region_count,
    output logic [ccl_pkg::LABEL_W-1:0]   o_cell_label,
    input  wire                           i_cfg_we,
    input  wire [ccl_pkg::CFG_A_W-1:0]    i_cfg_addr,
    input  wire [ccl_pkg::MASK_W-1:0]     i_cfg_data
);

    import ccl_pkg::*;

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int SW    = AW + XW + YW;
    localparam int CMP_W = (CNT_W > INDEX_W + 1) ? CNT_W : INDEX_W + 1;

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLEAR    = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CHK = 4'd3;
    localparam logic [3:0] S_POP      = 4'd4;
    localparam logic [3:0] S_POP_WAIT = 4'd5;
    localparam logic [3:0] S_NB_RD    = 4'd6;
    localparam logic [3:0] S_NB_CHK   = 4'd7;
    localparam logic [3:0] S_RD_PUT   = 4'd8;
    localparam logic [3:0] S_CNT_PUT  = 4'd9;

    // Configuration registers
    logic [DIM_W-1:0]  r_cfg_w, r_cfg_h;
    logic [MASK_W-1:0] r_cfg_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= DIM_W'(64);
            r_cfg_h    <= DIM_W'(64);
            r_cfg_mask <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_GRID_WIDTH:  r_cfg_w    <= i_cfg_data[DIM_W-1:0];
                CFG_GRID_HEIGHT: r_cfg_h    <= i_cfg_data[DIM_W-1:0];
                CFG_TYPE_MASK:   r_cfg_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped grid size and cell count
    logic [WW-1:0]    w_used;
    logic [HW-1:0]    h_used;
    logic [CNT_W-1:0] n_cells;

    always_comb begin
        if (r_cfg_w == '0) begin
            w_used = WW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_used = WW'(MAX_WIDTH);
        end else begin
            w_used = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_used = HW'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            h_used = HW'(MAX_HEIGHT);
        end else begin
            h_used = HW'(r_cfg_h);
        end
        n_cells = CNT_W'(w_used * h_used);
    end

    // Control and payload registers
    logic [3:0]         r_state, n_state;
    logic               r_boot, n_boot;
    logic [CNT_W-1:0]   r_load_ptr, n_load_ptr;
    logic [AW-1:0]      r_clr, n_clr;
    logic [CNT_W-1:0]   r_start, n_start;
    logic [XW-1:0]      r_sx, n_sx;
    logic [YW-1:0]      r_sy, n_sy;
    logic [LABEL_W-1:0] r_next_label, n_next_label;
    logic [CNT_W-1:0]   r_sp, n_sp;
    logic [1:0]         r_dir, n_dir;
    logic [SW-1:0]      r_cur, n_cur;
    logic [SW-1:0]      r_nb, n_nb;
    logic               r_rd_hit, n_rd_hit;
    logic               r_out_valid, n_out_valid;
    logic               r_kind, n_kind;
    logic [LABEL_W-1:0] r_count, n_count;
    logic [LABEL_W-1:0] r_label, n_label;

    // Memory port signals
    logic [AW-1:0]         cm_addr;
    logic                  cm_re, cm_we_type, cm_we_label;
    logic [LABEL_W-1:0]    cm_wlabel;
    logic [TYPE_BITS-1:0]  cm_rtype;
    logic [LABEL_W-1:0]    cm_rlabel;
    logic                  st_we, st_re;
    logic [AW-1:0]         st_waddr, st_raddr;
    logic [SW-1:0]         st_wdata, st_rdata;

    ccl_cell_mem #(
        .DEPTH  (CELLS),
        .TYPE_W (TYPE_BITS),
        .LAB_W  (LABEL_W)
    ) u_cell_mem (
        .i_clk      (i_clk),
        .i_addr     (cm_addr),
        .i_re       (cm_re),
        .i_we_type  (cm_we_type),
        .i_type     (i_cell_type),
        .i_we_label (cm_we_label),
        .i_label    (cm_wlabel),
        .o_type     (cm_rtype),
        .o_label    (cm_rlabel)
    );

    ccl_stack_mem #(
        .DEPTH (CELLS),
        .WIDTH (SW)
    ) u_stack_mem (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // Eligibility of the cell just read
    logic rd_elig;
    always_comb begin
        rd_elig = (32'(cm_rtype) < MASK_W) && r_cfg_mask[3'(cm_rtype)];
    end

    // Current cell fields and neighbour candidate for this direction
    logic [AW-1:0] cur_idx;
    logic [XW-1:0] cur_x;
    logic [YW-1:0] cur_y;
    logic          nb_in;
    logic [SW-1:0] nb_ent;

    assign cur_idx = r_cur[SW-1 -: AW];
    assign cur_x   = r_cur[YW +: XW];
    assign cur_y   = r_cur[YW-1:0];

    always_comb begin
        nb_in  = 1'b0;
        nb_ent = r_cur;
        case (r_dir)
            2'd0: begin
                nb_in  = (cur_x != '0);
                nb_ent = {cur_idx - AW'(1), cur_x - XW'(1), cur_y};
            end
            2'd1: begin
                nb_in  = (32'(cur_y) + 1 < 32'(h_used));
                nb_ent = {cur_idx + AW'(w_used), cur_x, cur_y + YW'(1)};
            end
            2'd2: begin
                nb_in  = (32'(cur_x) + 1 < 32'(w_used));
                nb_ent = {cur_idx + AW'(1), cur_x + XW'(1), cur_y};
            end
            default: begin
                nb_in  = (cur_y != '0);
                nb_ent = {cur_idx - AW'(w_used), cur_x, cur_y - YW'(1)};
            end
        endcase
    end

    logic in_xfer, out_xfer, out_free;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_xfer   = r_out_valid && i_out_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_boot       = r_boot;
        n_load_ptr   = r_load_ptr;
        n_clr        = r_clr;
        n_start      = r_start;
        n_sx         = r_sx;
        n_sy         = r_sy;
        n_next_label = r_next_label;
        n_sp         = r_sp;
        n_dir        = r_dir;
        n_cur        = r_cur;
        n_nb         = r_nb;
        n_rd_hit     = r_rd_hit;
        n_out_valid  = out_xfer ? 1'b0 : r_out_valid;
        n_kind       = r_kind;
        n_count      = r_count;
        n_label      = r_label;
        cm_addr      = '0;
        cm_re        = 1'b0;
        cm_we_type   = 1'b0;
        cm_we_label  = 1'b0;
        cm_wlabel    = '0;
        st_we        = 1'b0;
        st_waddr     = AW'(r_sp);
        st_wdata     = r_nb;
        st_re        = 1'b0;
        st_raddr     = AW'(r_sp - CNT_W'(1));

        case (r_state)
            S_IDLE: begin
                if (in_xfer && i_mode == MODE_LOAD) begin
                    if (r_load_ptr < n_cells) begin
                        cm_addr    = AW'(r_load_ptr);
                        cm_we_type = 1'b1;
                        n_load_ptr = r_load_ptr + CNT_W'(1);
                    end
                    if (i_last_cell) begin
                        n_load_ptr = '0;
                        n_clr      = '0;
                        n_state    = S_CLEAR;
                    end
                end else if (in_xfer) begin
                    n_rd_hit = (CMP_W'(i_cell_index) < CMP_W'(n_cells));
                    cm_addr  = AW'(i_cell_index);
                    cm_re    = n_rd_hit;
                    n_state  = S_RD_PUT;
                end
            end
            S_CLEAR: begin
                cm_addr     = r_clr;
                cm_we_label = 1'b1;
                n_clr       = r_clr + AW'(1);
                if (r_clr == AW'(CELLS - 1)) begin
                    n_boot       = 1'b0;
                    n_start      = '0;
                    n_sx         = '0;
                    n_sy         = '0;
                    n_next_label = LABEL_W'(1);
                    n_state      = r_boot ? S_IDLE : S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                cm_addr = AW'(r_start);
                cm_re   = 1'b1;
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK, S_POP: begin
                if (r_state == S_SCAN_CHK && rd_elig && cm_rlabel == '0) begin
                    // Seed a new region at the scan position
                    cm_addr      = AW'(r_start);
                    cm_we_label  = 1'b1;
                    cm_wlabel    = r_next_label;
                    st_we        = 1'b1;
                    st_waddr     = '0;
                    st_wdata     = {AW'(r_start), r_sx, r_sy};
                    n_sp         = CNT_W'(1);
                    n_next_label = r_next_label + LABEL_W'(1);
                    n_state      = S_POP;
                end else if (r_state == S_POP && r_sp != '0) begin
                    st_re   = 1'b1;
                    n_sp    = r_sp - CNT_W'(1);
                    n_state = S_POP_WAIT;
                end else begin
                    // Move the scan on by one cell
                    if (r_start + CNT_W'(1) == n_cells) begin
                        n_state = S_CNT_PUT;
                    end else begin
                        n_start = r_start + CNT_W'(1);
                        if (32'(r_sx) + 1 == 32'(w_used)) begin
                            n_sx = '0;
                            n_sy = r_sy + YW'(1);
                        end else begin
                            n_sx = r_sx + XW'(1);
                        end
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_POP_WAIT: begin
                n_cur   = st_rdata;
                n_dir   = 2'd0;
                n_state = S_NB_RD;
            end
            S_NB_RD: begin
                if (nb_in) begin
                    cm_addr = nb_ent[SW-1 -: AW];
                    cm_re   = 1'b1;
                    n_nb    = nb_ent;
                    n_state = S_NB_CHK;
                end else begin
                    n_dir   = r_dir + 2'd1;
                    n_state = (r_dir == 2'd3) ? S_POP : S_NB_RD;
                end
            end
            S_NB_CHK: begin
                if (rd_elig && cm_rlabel == '0) begin
                    cm_addr     = r_nb[SW-1 -: AW];
                    cm_we_label = 1'b1;
                    cm_wlabel   = r_next_label - LABEL_W'(1);
                    st_we       = 1'b1;
                    n_sp        = r_sp + CNT_W'(1);
                end
                n_dir   = r_dir + 2'd1;
                n_state = (r_dir == 2'd3) ? S_POP : S_NB_RD;
            end
            S_RD_PUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_LABEL;
                    n_count     = '0;
                    n_label     = r_rd_hit ? cm_rlabel : '0;
                    n_state     = S_IDLE;
                end
            end
            S_CNT_PUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_COUNT;
                    n_count     = r_next_label - LABEL_W'(1);
                    n_label     = '0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_boot       <= 1'b1;
            r_clr        <= '0;
            r_load_ptr   <= '0;
            r_next_label <= LABEL_W'(1);
            r_sp         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_boot       <= n_boot;
            r_clr        <= n_clr;
            r_load_ptr   <= n_load_ptr;
            r_next_label <= n_next_label;
            r_sp         <= n_sp;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_start  <= n_start;
        r_sx     <= n_sx;
        r_sy     <= n_sy;
        r_dir    <= n_dir;
        r_cur    <= n_cur;
        r_nb     <= n_nb;
        r_rd_hit <= n_rd_hit;
        r_kind   <= n_kind;
        r_count  <= n_count;
        r_label  <= n_label;
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_region_count = r_count;
    assign o_cell_label   = r_label;

    // Checks
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= n_cells)
        else $error("fill stack deeper than grid");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_mode == MODE_LOAD && i_last_cell) |=> (r_state == S_CLEAR))
        else $error("last cell did not start clearing");

    a_count_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CNT_PUT) |-> (r_load_ptr == '0))
        else $error("load pointer not rewound after labelling");

    a_label_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_LABEL) |-> (r_count == '0))
        else $error("read result carries a count");

    a_put_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RD_PUT || r_state == S_CNT_PUT) && out_free) |=> (r_state == S_IDLE))
        else $error("result not issued");

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the grid region labeller: random grids, loads and label reads.
`default_nettype none

module tb;
    import ccl_pkg::*;

    localparam int GRID_MAX_W = DEF_MAX_WIDTH;
    localparam int GRID_MAX_H = DEF_MAX_HEIGHT;
    localparam int CELL_CNT   = GRID_MAX_W * GRID_MAX_H;

    typedef struct packed {
        logic                 mode;
        logic [2:0]           ctype;
        logic                 last;
        logic [INDEX_W-1:0]   idx;
    } t_cell_item;

    typedef struct packed {
        logic                 kind;
        logic [LABEL_W-1:0]   count;
        logic [LABEL_W-1:0]   label;
    } t_label_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_mode;
    logic [2:0]           i_cell_type;
    logic                 i_last_cell;
    logic [INDEX_W-1:0]   i_cell_index;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_kind;
    logic [LABEL_W-1:0]   o_region_count;
    logic [LABEL_W-1:0]   o_cell_label;
    logic                 i_cfg_we;
    logic [CFG_A_W-1:0]   i_cfg_addr;
    logic [MASK_W-1:0]    i_cfg_data;

    grid_connected_component_labeler_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_cell_type    (i_cell_type),
        .i_last_cell    (i_last_cell),
        .i_cell_index   (i_cell_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_region_count (o_region_count),
        .o_cell_label   (o_cell_label),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Queues and counters
    t_cell_item    pending_cells[$];
    t_label_result expected_labels[$];
    int            fail_cnt   = 0;
    int            grids_run  = 0;
    int            reads_run  = 0;
    int            loads_run  = 0;
    int            items_gen  = 0;

    // Mirror of the block's state
    logic [6:0]          shadow_w;
    logic [6:0]          shadow_h;
    logic [7:0]          shadow_mask;
    logic [2:0]          shadow_type[CELL_CNT];
    logic [LABEL_W-1:0]  shadow_label[CELL_CNT];
    int                  shadow_ptr;
    int                  shadow_next;

    // Generator-side knowledge of which cells hold a loaded type
    bit                  cell_written[CELL_CNT];

    function automatic int dim_used(input int v, input int vmax);
        if (v == 0) return 1;
        if (v > vmax) return vmax;
        return v;
    endfunction

    function automatic bit is_eligible(input int idx);
        return shadow_mask[shadow_type[idx]];
    endfunction

    // Flood fill over the mirrored grid, explicit stack, same visiting order
    function automatic void relabel_grid();
        int w;
        int h;
        int n;
        int sp;
        int cur;
        int x;
        int y;
        int nb[4];
        logic [LABEL_W-1:0] lab;
        int fill_stk[CELL_CNT];
        w = dim_used(shadow_w, GRID_MAX_W);
        h = dim_used(shadow_h, GRID_MAX_H);
        n = w * h;
        for (int i = 0; i < CELL_CNT; i++) shadow_label[i] = '0;
        shadow_next = 1;
        for (int s = 0; s < n; s++) begin
            if (shadow_label[s] != 0 || !is_eligible(s)) continue;
            lab = shadow_next[LABEL_W-1:0];
            shadow_next++;
            shadow_label[s] = lab;
            fill_stk[0] = s;
            sp = 1;
            while (sp > 0) begin
                sp--;
                cur = fill_stk[sp];
                x = cur % w;
                y = cur / w;
                nb[0] = (x > 0)     ? cur - 1 : -1;
                nb[1] = (y + 1 < h) ? cur + w : -1;
                nb[2] = (x + 1 < w) ? cur + 1 : -1;
                nb[3] = (y > 0)     ? cur - w : -1;
                for (int k = 0; k < 4; k++) begin
                    if (nb[k] >= 0 && shadow_label[nb[k]] == 0 && is_eligible(nb[k])) begin
                        shadow_label[nb[k]] = lab;
                        fill_stk[sp] = nb[k];
                        sp++;
                    end
                end
            end
        end
    endfunction

    // Work out the result of one accepted item
    function automatic void predict_labels(input t_cell_item it);
        int n;
        t_label_result r;
        n = dim_used(shadow_w, GRID_MAX_W) * dim_used(shadow_h, GRID_MAX_H);
        r = '0;
        if (it.mode == MODE_LOAD) begin
            if (shadow_ptr < n) begin
                shadow_type[shadow_ptr] = it.ctype;
                shadow_ptr++;
            end
            if (it.last) begin
                relabel_grid();
                shadow_ptr = 0;
                r.kind  = KIND_COUNT;
                r.count = LABEL_W'(shadow_next - 1);
                expected_labels = {expected_labels, r};
            end
        end else begin
            r.kind = KIND_LABEL;
            if (int'(it.idx) < n) r.label = shadow_label[it.idx];
            expected_labels = {expected_labels, r};
        end
    endfunction

    // Driver: bursts of transfers with random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        t_cell_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                predict_labels('{i_mode, i_cell_type, i_last_cell, i_cell_index});
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_cells.size() > 0) begin
                    nxt = pending_cells.pop_front();
                    i_in_valid   <= 1'b1;
                    i_mode       <= nxt.mode;
                    i_cell_type  <= nxt.ctype;
                    i_last_cell  <= nxt.last;
                    i_cell_index <= nxt.idx;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        case ($urandom_range(0, 3))
                            0: gap_left <= 0;
                            1: gap_left <= $urandom_range(1, 3);
                            2: gap_left <= $urandom_range(1, 8);
                            default: gap_left <= $urandom_range(10, 40);
                        endcase
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: receiver stalls on a changing pattern, results checked in order
    int stall_mode = 0;
    int stall_cyc  = 0;

    always @(posedge i_clk) begin
        t_label_result exp_r;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_labels.size() == 0) begin
                    $display("%0t: unexpected transfer kind=%0d count=%0d label=%0d",
                             $time, o_kind, o_region_count, o_cell_label);
                    fail_cnt++;
                end else begin
                    exp_r = expected_labels.pop_front();
                    if (o_kind !== exp_r.kind) begin
                        $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, o_kind);
                        fail_cnt++;
                    end
                    if (o_region_count !== exp_r.count) begin
                        $display("%0t: region_count expected %0d actual %0d",
                                 $time, exp_r.count, o_region_count);
                        fail_cnt++;
                    end
                    if (o_cell_label !== exp_r.label) begin
                        $display("%0t: cell_label expected %0d actual %0d",
                                 $time, exp_r.label, o_cell_label);
                        fail_cnt++;
                    end
                end
            end
            if (stall_cyc == 0) begin
                stall_mode <= $urandom_range(0, 2);
                stall_cyc  <= $urandom_range(16, 200);
            end else begin
                stall_cyc <= stall_cyc - 1;
            end
            case (stall_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= $urandom_range(0, 1);
                default: i_out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Wait for every expected result plus a margin for trailing loads
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_cells.size() != 0 || i_in_valid || expected_labels.size() != 0);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] addr, input logic [7:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (addr)
            CFG_GRID_WIDTH:  shadow_w    = val[6:0];
            CFG_GRID_HEIGHT: shadow_h    = val[6:0];
            default:         shadow_mask = val;
        endcase
        @(posedge i_clk);
    endtask

    task automatic queue_read(input int n);
        t_cell_item it;
        it       = '0;
        it.mode  = MODE_READ;
        it.ctype = $urandom_range(0, 7);
        it.last  = $urandom_range(0, 1);
        if ($urandom_range(0, 9) < 7)
            it.idx = $urandom_range(0, (n + 3 > 4095) ? 4095 : n + 3);
        else
            it.idx = $urandom_range(0, 4095);
        pending_cells = {pending_cells, it};
        reads_run++;
        items_gen++;
    endtask

    // One grid: loads with random content, odd early or overlong ends, stray reads
    task automatic queue_grid(input int n, input logic [7:0] mask);
        t_cell_item it;
        int total;
        int dens;
        bit ok;
        total = n;
        // early last cell only where the skipped cells were loaded before
        if ($urandom_range(0, 9) == 0) begin
            total = $urandom_range(1, n);
            ok = 1;
            for (int i = total; i < n; i++) if (!cell_written[i]) ok = 0;
            if (!ok) total = n;
        end else if ($urandom_range(0, 9) == 0) begin
            total = n + $urandom_range(1, 3);
        end
        dens = $urandom_range(20, 95);
        for (int i = 0; i < total; i++) begin
            if ($urandom_range(0, 19) == 0) queue_read(n);
            it       = '0;
            it.mode  = MODE_LOAD;
            it.idx   = $urandom_range(0, 4095);
            it.ctype = $urandom_range(0, 7);
            if (mask != 0 && $urandom_range(0, 99) < dens)
                while (!mask[it.ctype]) it.ctype = $urandom_range(0, 7);
            it.last  = (i == total - 1);
            if (i < n) cell_written[i] = 1'b1;
            pending_cells = {pending_cells, it};
            loads_run++;
            items_gen++;
        end
        grids_run++;
    endtask

    // One phase: new registers, reads under the new size, then grids and reads
    task automatic run_phase(input int w, input int h, input logic [7:0] mask,
                             input int grids, input int reads);
        int n;
        wait_idle();
        write_reg(CFG_GRID_WIDTH,  w[7:0]);
        write_reg(CFG_GRID_HEIGHT, h[7:0]);
        write_reg(CFG_TYPE_MASK,   mask);
        n = dim_used(w, GRID_MAX_W) * dim_used(h, GRID_MAX_H);
        for (int i = 0; i < 3; i++) queue_read(n);
        for (int g = 0; g < grids; g++) begin
            queue_grid(n, mask);
            for (int i = 0; i < reads; i++) queue_read(n);
        end
    endtask

    // Stimulus
    initial begin
        int w;
        int h;
        logic [7:0] mask;
        i_rst_n      = 1'b0;
        i_mode       = 1'b0;
        i_cell_type  = '0;
        i_last_cell  = 1'b0;
        i_cell_index = '0;
        i_cfg_we     = 1'b0;
        i_cfg_addr   = '0;
        i_cfg_data   = '0;
        shadow_w     = 7'd64;
        shadow_h     = 7'd64;
        shadow_mask  = 8'h00;
        shadow_ptr   = 0;
        shadow_next  = 1;
        for (int i = 0; i < CELL_CNT; i++) begin
            shadow_type[i]  = '0;
            shadow_label[i] = '0;
            cell_written[i] = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reads before any labelling, at the reset size
        pending_cells = {pending_cells, t_cell_item'{MODE_READ, 3'd7, 1'b1, 12'd0}};
        pending_cells = {pending_cells, t_cell_item'{MODE_READ, 3'd0, 1'b0, 12'd4095}};
        reads_run += 2;
        items_gen += 2;

        // directed: clamped sizes, single row and column, empty and full masks
        run_phase(0,   0,   8'hFF, 1, 2);
        run_phase(127, 1,   8'h55, 1, 4);
        run_phase(1,   127, 8'hAA, 1, 4);
        run_phase(3,   2,   8'h00, 1, 3);
        run_phase(64,  4,   8'hFF, 1, 4);
        run_phase(5,   4,   8'h80, 2, 3);

        // random phases, mostly small grids
        while (items_gen < 1900) begin
            case ($urandom_range(0, 9))
                0:       w = 0;
                1:       w = $urandom_range(64, 127);
                2:       w = $urandom_range(9, 32);
                default: w = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 9))
                0:       h = 0;
                1:       h = $urandom_range(64, 127);
                2:       h = $urandom_range(9, 32);
                default: h = $urandom_range(1, 8);
            endcase
            while (dim_used(w, GRID_MAX_W) * dim_used(h, GRID_MAX_H) > 256) h = h / 2;
            case ($urandom_range(0, 5))
                0:       mask = 8'h00;
                1:       mask = 8'hFF;
                default: mask = $urandom_range(0, 255);
            endcase
            run_phase(w, h, mask, $urandom_range(1, 3), $urandom_range(2, 10));
        end

        wait_idle();
        repeat (200) @(posedge i_clk);
        $display("Covered %0d grids, %0d cell loads and %0d label reads", grids_run,
                 loads_run, reads_run);
        if (fail_cnt == 0 && expected_labels.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #200_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
